>>> rtl/midi_byte_stream_parser_core_defines.svh
// assertion macros for the midi byte stream parser checker
// no dependencies; included by the checker file only
`ifndef MIDI_BYTE_STREAM_PARSER_CORE_DEFINES_SVH
`define MIDI_BYTE_STREAM_PARSER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MBSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MBSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mbsp_pkg.sv
// shared types, codes and decode helpers for the midi byte stream parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mbsp_pkg;

    // sysex byte limit and counter width
    localparam int SYSEX_LIMIT  = 32768;
    localparam int SYSEX_CNT_W  = $clog2(SYSEX_LIMIT);

    // result kinds
    localparam logic [3:0] KIND_MESSAGE  = 4'd0;
    localparam logic [3:0] KIND_SONG_POS = 4'd1;
    localparam logic [3:0] KIND_CLOCK    = 4'd2;
    localparam logic [3:0] KIND_START    = 4'd3;
    localparam logic [3:0] KIND_CONTINUE = 4'd4;
    localparam logic [3:0] KIND_STOP     = 4'd5;
    localparam logic [3:0] KIND_QFRAME   = 4'd6;
    localparam logic [3:0] KIND_SX_BYTE  = 4'd7;
    localparam logic [3:0] KIND_SX_END   = 4'd8;

    // byte classes decided by the front end
    localparam logic [1:0] CLS_DATA   = 2'd0;
    localparam logic [1:0] CLS_STATUS = 2'd1;
    localparam logic [1:0] CLS_RT     = 2'd2;

    // status byte values with special handling
    localparam logic [7:0] ST_SX_START  = 8'hF0;
    localparam logic [7:0] ST_QFRAME    = 8'hF1;
    localparam logic [7:0] ST_SONG_POS  = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
    localparam logic [7:0] ST_SX_END    = 8'hF7;
    localparam logic [7:0] ST_RT_FIRST  = 8'hF8;
    localparam logic [7:0] ST_CLOCK     = 8'hF8;
    localparam logic [7:0] ST_START     = 8'hFA;
    localparam logic [7:0] ST_CONTINUE  = 8'hFB;
    localparam logic [7:0] ST_STOP      = 8'hFC;

    // configuration register indexes
    localparam logic [1:0] CFG_SYSEX_CAPTURE = 2'd0;
    localparam logic [1:0] CFG_CLOCK_FORWARD = 2'd1;

    // data bytes per channel status, by upper nibble minus 8
    localparam logic [1:0] LEN_TABLE [8] = '{2'd2, 2'd2, 2'd2, 2'd2,
                                             2'd1, 2'd1, 2'd2, 2'd0};

    // classified byte passed from front end to back end
    typedef struct packed {
        logic [7:0] byte_val;
        logic       ovr;
        logic [1:0] cls;
        logic       rt_fwd;
        logic [3:0] rt_kind;
        logic [1:0] data_len;
        logic       is_sx_start;
        logic       is_tc_mark;
        logic       is_sx_end;
    } op_t;

    // one result item
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] status_byte;
        logic [7:0] first_data;
        logic [6:0] second_data;
        logic       sysex_overflow;
        logic       last_result;
    } res_t;

    // data bytes that follow a status byte
    function automatic logic [1:0] data_length(input logic [7:0] st);
        logic [1:0] len;
        len = 2'd0;
        if (st < ST_SX_START)
        begin
            len = LEN_TABLE[st[6:4]];
        end
        else if (st == ST_SX_START || st == ST_QFRAME || st == ST_SONG_SEL)
        begin
            len = 2'd1;
        end
        else if (st == ST_SONG_POS)
        begin
            len = 2'd2;
        end
        return len;
    endfunction

endpackage

>>> rtl/mbsp_front.sv
// front end: accepts received bytes and classifies them into ops
// depends on mbsp_pkg; feeds mbsp_queue
`timescale 1ns / 1ps

module mbsp_front
    import mbsp_pkg::*;
(
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       overrun,
    input  logic       q_full,
    output logic       push,
    output op_t        push_op
);

    // handshake towards the queue
    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // byte classification
    always_comb
    begin
        push_op             = '0;
        push_op.byte_val    = rx_byte;
        push_op.ovr         = overrun;
        push_op.data_len    = data_length(rx_byte);
        push_op.is_sx_start = (rx_byte == ST_SX_START);
        push_op.is_tc_mark  = (rx_byte == ST_QFRAME);
        push_op.is_sx_end   = (rx_byte == ST_SX_END);
        if (!rx_byte[7])
        begin
            push_op.cls = CLS_DATA;
        end
        else if (rx_byte >= ST_RT_FIRST)
        begin
            push_op.cls = CLS_RT;
        end
        else
        begin
            push_op.cls = CLS_STATUS;
        end
        // real-time bytes that may be forwarded
        case (rx_byte)
            ST_CLOCK:
            begin
                push_op.rt_fwd  = 1'b1;
                push_op.rt_kind = KIND_CLOCK;
            end
            ST_START:
            begin
                push_op.rt_fwd  = 1'b1;
                push_op.rt_kind = KIND_START;
            end
            ST_CONTINUE:
            begin
                push_op.rt_fwd  = 1'b1;
                push_op.rt_kind = KIND_CONTINUE;
            end
            ST_STOP:
            begin
                push_op.rt_fwd  = 1'b1;
                push_op.rt_kind = KIND_STOP;
            end
            default:
            begin
                push_op.rt_fwd  = 1'b0;
                push_op.rt_kind = KIND_MESSAGE;
            end
        endcase
    end

endmodule

>>> rtl/mbsp_queue.sv
// two-entry queue of classified ops between front and back end
// depends on mbsp_pkg
`timescale 1ns / 1ps

module mbsp_queue
    import mbsp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output op_t  head_op
);

    op_t        slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_op    = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

>>> rtl/mbsp_back.sv
// back end: parser state, result generation and output register
// depends on mbsp_pkg; consumes ops from mbsp_queue
`timescale 1ns / 1ps

module mbsp_back
    import mbsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic       cfg_data,
    input  logic       q_valid,
    input  op_t        q_op,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output res_t       out_res
);

    // configuration
    logic sysex_capture_enable_reg;
    logic clock_forward_enable_reg;

    // parser state
    logic [7:0]             running_status_reg;
    logic [7:0]             running_status_next;
    logic [1:0]             needed_data_reg;
    logic [1:0]             needed_data_next;
    logic [1:0]             data_position_reg;
    logic [1:0]             data_position_next;
    logic                   status_unknown_reg;
    logic                   status_unknown_next;
    logic                   in_sysex_reg;
    logic                   in_sysex_next;
    logic                   timecode_pending_reg;
    logic                   timecode_pending_next;
    logic [7:0]             held_first_data_reg;
    logic [7:0]             held_first_data_next;
    logic [SYSEX_CNT_W-1:0] sysex_count_reg;
    logic [SYSEX_CNT_W-1:0] sysex_count_next;
    logic                   sysex_overflowed_reg;
    logic                   sysex_overflowed_next;

    // output register and second-result holding stage
    logic out_valid_reg;
    res_t out_res_reg;
    logic pend_valid_reg;
    res_t pend_res_reg;

    // per-op results
    logic       end_v;
    res_t       end_res;
    logic       main_v;
    res_t       main_res;
    logic       handled;
    logic [1:0] pos;
    logic [7:0] held;
    logic       out_load;
    logic       proc;
    res_t       r0;
    res_t       r1;

    assign out_load  = !out_valid_reg || out_ready;
    assign proc      = q_valid && !pend_valid_reg && out_load;
    assign q_pop     = proc;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // state update and results for the op at the queue head
    always_comb
    begin
        running_status_next   = running_status_reg;
        needed_data_next      = needed_data_reg;
        data_position_next    = data_position_reg;
        status_unknown_next   = status_unknown_reg | q_op.ovr;
        in_sysex_next         = in_sysex_reg;
        timecode_pending_next = timecode_pending_reg;
        held_first_data_next  = held_first_data_reg;
        sysex_count_next      = sysex_count_reg;
        sysex_overflowed_next = sysex_overflowed_reg;
        end_v    = 1'b0;
        end_res  = '0;
        main_v   = 1'b0;
        main_res = '0;
        handled  = 1'b0;
        pos      = data_position_reg + 2'd1;
        held     = (pos == 2'd1) ? q_op.byte_val : held_first_data_reg;
        case (q_op.cls)
            CLS_RT:
            begin
                main_v               = clock_forward_enable_reg && q_op.rt_fwd;
                main_res.kind        = q_op.rt_kind;
                main_res.status_byte = q_op.byte_val;
            end
            CLS_STATUS:
            begin
                // any status byte ends a running sysex
                if (in_sysex_reg)
                begin
                    end_v                  = sysex_capture_enable_reg;
                    end_res.kind           = KIND_SX_END;
                    end_res.status_byte    = ST_SX_END;
                    end_res.first_data     = ST_SX_END;
                    end_res.sysex_overflow = sysex_overflowed_reg;
                    in_sysex_next          = 1'b0;
                    status_unknown_next    = 1'b1;
                    handled                = q_op.is_sx_end;
                end
                if (!handled)
                begin
                    if (q_op.is_tc_mark)
                    begin
                        timecode_pending_next = 1'b1;
                    end
                    else
                    begin
                        running_status_next = q_op.byte_val;
                        needed_data_next    = q_op.data_len;
                        data_position_next  = 2'd0;
                        status_unknown_next = 1'b0;
                        // sysex start counts as its first streamed byte
                        if (q_op.is_sx_start)
                        begin
                            in_sysex_next         = 1'b1;
                            sysex_overflowed_next = 1'b0;
                            sysex_count_next      = SYSEX_CNT_W'(1);
                            main_v                = sysex_capture_enable_reg;
                            main_res.kind         = KIND_SX_BYTE;
                            main_res.status_byte  = ST_SX_START;
                            main_res.first_data   = q_op.byte_val;
                        end
                    end
                end
            end
            CLS_DATA:
            begin
                if (timecode_pending_reg)
                begin
                    timecode_pending_next = 1'b0;
                    main_v                = 1'b1;
                    main_res.kind         = KIND_QFRAME;
                    main_res.status_byte  = ST_QFRAME;
                    main_res.first_data   = q_op.byte_val;
                end
                else if (in_sysex_reg)
                begin
                    // saturate at the sysex limit minus one
                    if (sysex_count_reg < SYSEX_CNT_W'(SYSEX_LIMIT - 1))
                    begin
                        sysex_count_next     = sysex_count_reg + SYSEX_CNT_W'(1);
                        main_v               = sysex_capture_enable_reg;
                        main_res.kind        = KIND_SX_BYTE;
                        main_res.status_byte = ST_SX_START;
                        main_res.first_data  = q_op.byte_val;
                    end
                    else
                    begin
                        sysex_overflowed_next = 1'b1;
                    end
                end
                else if (!status_unknown_next && needed_data_reg != 2'd0)
                begin
                    held_first_data_next = held;
                    data_position_next   = pos;
                    // message complete
                    if (pos >= needed_data_reg)
                    begin
                        data_position_next   = 2'd0;
                        main_res.status_byte = running_status_reg;
                        main_res.first_data  = held;
                        main_res.second_data = (needed_data_reg == 2'd2) ?
                                               q_op.byte_val[6:0] : 7'd0;
                        if (running_status_reg == ST_SONG_POS)
                        begin
                            main_v        = clock_forward_enable_reg;
                            main_res.kind = KIND_SONG_POS;
                        end
                        else
                        begin
                            main_v        = 1'b1;
                            main_res.kind = KIND_MESSAGE;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // order results: sysex end first, then the main result
    always_comb
    begin
        r0             = end_v ? end_res : main_res;
        r0.last_result = !(end_v && main_v);
        r1             = main_res;
        r1.last_result = 1'b1;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sysex_capture_enable_reg <= 1'b0;
            clock_forward_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SYSEX_CAPTURE)
            begin
                sysex_capture_enable_reg <= cfg_data;
            end
            if (cfg_index == CFG_CLOCK_FORWARD)
            begin
                clock_forward_enable_reg <= cfg_data;
            end
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_status_reg   <= 8'd0;
            needed_data_reg      <= 2'd0;
            data_position_reg    <= 2'd0;
            status_unknown_reg   <= 1'b1;
            in_sysex_reg         <= 1'b0;
            timecode_pending_reg <= 1'b0;
            held_first_data_reg  <= 8'd0;
            sysex_count_reg      <= '0;
            sysex_overflowed_reg <= 1'b0;
        end
        else if (proc)
        begin
            running_status_reg   <= running_status_next;
            needed_data_reg      <= needed_data_next;
            data_position_reg    <= data_position_next;
            status_unknown_reg   <= status_unknown_next;
            in_sysex_reg         <= in_sysex_next;
            timecode_pending_reg <= timecode_pending_next;
            held_first_data_reg  <= held_first_data_next;
            sysex_count_reg      <= sysex_count_next;
            sysex_overflowed_reg <= sysex_overflowed_next;
        end
    end

    // output valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg  <= proc && (end_v || main_v);
                pend_valid_reg <= proc && end_v && main_v;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (pend_valid_reg)
            begin
                out_res_reg <= pend_res_reg;
            end
            else if (proc)
            begin
                out_res_reg  <= r0;
                pend_res_reg <= r1;
            end
        end
    end

endmodule

>>> rtl/midi_byte_stream_parser_core.sv
// top level of the midi byte stream parser
// depends on mbsp_pkg, mbsp_front, mbsp_queue and mbsp_back
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_ready   rx_byte, overrun
//  result    out        out_valid / out_ready kind .. last_result
//  config    in         cfg_we (no wait)      cfg_index, cfg_data
//
// one byte per cycle while the output is not stalled, when it gives at most
// one result; a byte that gives a sysex end plus a new sysex start holds
// the back end until its second result is loaded; an accepted byte is
// written into the queue and goes from the queue head to the output reg
// reset clears all parser state, the queue and the output stage
// a stalled output fills the two-entry queue before in_ready drops
`timescale 1ns / 1ps

module midi_byte_stream_parser_core
    import mbsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       overrun,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] kind,
    output logic [7:0] status_byte,
    output logic [7:0] first_data,
    output logic [6:0] second_data,
    output logic       sysex_overflow,
    output logic       last_result,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic       cfg_data
);

    logic q_full;
    logic push;
    op_t  push_op;
    logic q_pop;
    logic q_valid;
    op_t  q_op;
    res_t out_res;

    // byte classification
    mbsp_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .overrun  (overrun),
        .q_full   (q_full),
        .push     (push),
        .push_op  (push_op)
    );

    // decoupling queue
    mbsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_op    (q_op)
    );

    // parser state and result output
    mbsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    // result fields onto ports
    assign kind           = out_res.kind;
    assign status_byte    = out_res.status_byte;
    assign first_data     = out_res.first_data;
    assign second_data    = out_res.second_data;
    assign sysex_overflow = out_res.sysex_overflow;
    assign last_result    = out_res.last_result;

endmodule

>>> rtl/mbsp_checker.sv
// port-level checks for the midi byte stream parser, bound to the top level
// depends on mbsp_pkg and midi_byte_stream_parser_core_defines.svh
`timescale 1ns / 1ps
`include "midi_byte_stream_parser_core_defines.svh"

module mbsp_checker
    import mbsp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] rx_byte,
    input logic       overrun,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] kind,
    input logic [7:0] status_byte,
    input logic [7:0] first_data,
    input logic [6:0] second_data,
    input logic       sysex_overflow,
    input logic       last_result,
    input logic       cfg_we,
    input logic [1:0] cfg_index,
    input logic       cfg_data
);

    // a stalled result item holds its kind, first data and last flag
    `MBSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(first_data) && $stable(last_result), "result item changed while stalled")

    // only sysex end carries the overflow flag
    `MBSP_ASSERT_NOW(a_ovf_only_end, out_valid && sysex_overflow, kind == KIND_SX_END, "overflow flag on a non-end item")

    // second data only on messages and song position
    `MBSP_ASSERT_NOW(a_d2_kinds, out_valid && second_data != 7'd0, kind == KIND_MESSAGE || kind == KIND_SONG_POS, "second data on a short kind")

    // the first of a result pair is always a sysex end
    `MBSP_ASSERT_NOW(a_pair_order, out_valid && !last_result, kind == KIND_SX_END, "non-final item is not a sysex end")

    // quarter frames carry their marker status
    `MBSP_ASSERT_NOW(a_qframe_status, out_valid && kind == KIND_QFRAME, status_byte == ST_QFRAME, "quarter frame with wrong status")

endmodule

bind midi_byte_stream_parser_core mbsp_checker u_mbsp_checker (.*);

>>> tb/tb_midi_byte_stream_parser_core.sv
// self-checking testbench for midi_byte_stream_parser_core: drives MIDI bytes,
// frames them with its own running-status model and compares every result item
// depends on mbsp_pkg and the rtl of the parser core
`timescale 1ns / 1ps

module tb_midi_byte_stream_parser_core;
    import mbsp_pkg::*;

    // status values used by the stimulus
    localparam logic [7:0] STAT_NOTE_OFF     = 8'h80;
    localparam logic [7:0] STAT_PROG_CHANGE  = 8'hC0;
    localparam logic [7:0] STAT_PITCH_BEND   = 8'hE0;
    localparam logic [7:0] STAT_CHANNEL_LAST = 8'hEF;
    localparam logic [7:0] STAT_TUNE_REQ     = 8'hF6;
    localparam logic [7:0] RT_UNDEF          = 8'hF9;
    localparam logic [7:0] RT_LAST           = 8'hFF;
    localparam logic [7:0] DATA_MAX          = 8'h7F;

    // register indexes that select nothing
    localparam logic [1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [1:0] CFG_UNUSED_HI = 2'd3;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [7:0] value;
        logic       ovr;
    } midi_item_t;

    // dut ports
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       overrun = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [3:0] kind;
    logic [7:0] status_byte;
    logic [7:0] first_data;
    logic [6:0] second_data;
    logic       sysex_overflow;
    logic       last_result;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = 2'd0;
    logic       cfg_data = 1'b0;

    // stimulus and scoreboard
    midi_item_t pending_bytes[$];
    res_t       expected_results[$];
    midi_item_t next_item;
    int         bytes_queued = 0;
    int         bytes_taken = 0;
    int         fails = 0;
    int         quiet_cycles = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic       byte_taken = 1'b0;

    // framer copy: configuration and state
    logic        capture_on = 1'b0;
    logic        clock_fwd_on = 1'b0;
    logic [7:0]  cur_status = 8'h00;
    logic [1:0]  data_need = 2'd0;
    logic [1:0]  data_seen = 2'd0;
    logic        status_lost = 1'b1;
    logic        sx_active = 1'b0;
    logic        qframe_armed = 1'b0;
    logic [7:0]  first_held = 8'h00;
    int          sx_bytes = 0;
    logic        sx_overflowed = 1'b0;

    midi_byte_stream_parser_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .overrun        (overrun),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .status_byte    (status_byte),
        .first_data     (first_data),
        .second_data    (second_data),
        .sysex_overflow (sysex_overflow),
        .last_result    (last_result),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // data bytes that a status byte asks for
    function automatic logic [1:0] data_bytes_for(input logic [7:0] st);
        logic [1:0] len;
        len = 2'd0;
        if (st < ST_SX_START)
        begin
            len = (st[7:4] == 4'hC || st[7:4] == 4'hD) ? 2'd1 : 2'd2;
        end
        else
        begin
            case (st)
                ST_SX_START, ST_QFRAME, ST_SONG_SEL: len = 2'd1;
                ST_SONG_POS: len = 2'd2;
                default: len = 2'd0;
            endcase
        end
        return len;
    endfunction

    function automatic res_t make_result(input logic [3:0] k, input logic [7:0] st,
                                         input logic [7:0] d1, input logic [6:0] d2,
                                         input logic ovf);
        res_t r;
        r.kind = k;
        r.status_byte = st;
        r.first_data = d1;
        r.second_data = d2;
        r.sysex_overflow = ovf;
        r.last_result = 1'b0;
        return r;
    endfunction

    // counts one sysex byte, returns whether it is still under the limit
    function automatic logic count_sysex_byte();
        logic streamed;
        streamed = (sx_bytes < SYSEX_LIMIT - 1);
        if (streamed)
        begin
            sx_bytes = sx_bytes + 1;
        end
        else
        begin
            sx_overflowed = 1'b1;
        end
        return streamed;
    endfunction

    // frames one accepted byte and appends the results it causes
    task automatic frame_byte(input logic [7:0] b, input logic ovr);
        res_t       found[2];
        int         n;
        logic       handled;
        logic [6:0] d2;
        n = 0;
        if (ovr)
        begin
            status_lost = 1'b1;
        end
        if (b[7])
        begin
            if (b >= ST_RT_FIRST)
            begin
                // real-time bytes pass through untouched state
                if (clock_fwd_on)
                begin
                    case (b)
                        ST_CLOCK:
                        begin
                            found[n] = make_result(KIND_CLOCK, b, 8'h00, 7'h00, 1'b0);
                            n++;
                        end
                        ST_START:
                        begin
                            found[n] = make_result(KIND_START, b, 8'h00, 7'h00, 1'b0);
                            n++;
                        end
                        ST_CONTINUE:
                        begin
                            found[n] = make_result(KIND_CONTINUE, b, 8'h00, 7'h00, 1'b0);
                            n++;
                        end
                        ST_STOP:
                        begin
                            found[n] = make_result(KIND_STOP, b, 8'h00, 7'h00, 1'b0);
                            n++;
                        end
                        default: ;
                    endcase
                end
            end
            else
            begin
                handled = 1'b0;
                // any status byte closes a running sysex
                if (sx_active)
                begin
                    if (capture_on)
                    begin
                        found[n] = make_result(KIND_SX_END, ST_SX_END, ST_SX_END, 7'h00,
                                               sx_overflowed);
                        n++;
                    end
                    sx_active = 1'b0;
                    status_lost = 1'b1;
                    handled = (b == ST_SX_END);
                end
                if (!handled)
                begin
                    if (b == ST_QFRAME)
                    begin
                        qframe_armed = 1'b1;
                    end
                    else
                    begin
                        cur_status = b;
                        data_need = data_bytes_for(b);
                        data_seen = 2'd0;
                        status_lost = 1'b0;
                        if (b == ST_SX_START)
                        begin
                            sx_active = 1'b1;
                            sx_bytes = 0;
                            sx_overflowed = 1'b0;
                            if (count_sysex_byte() && capture_on)
                            begin
                                found[n] = make_result(KIND_SX_BYTE, ST_SX_START, b,
                                                       7'h00, 1'b0);
                                n++;
                            end
                        end
                    end
                end
            end
        end
        else if (qframe_armed)
        begin
            qframe_armed = 1'b0;
            found[n] = make_result(KIND_QFRAME, ST_QFRAME, b, 7'h00, 1'b0);
            n++;
        end
        else if (sx_active)
        begin
            if (count_sysex_byte() && capture_on)
            begin
                found[n] = make_result(KIND_SX_BYTE, ST_SX_START, b, 7'h00, 1'b0);
                n++;
            end
        end
        else if (!status_lost && data_need != 2'd0)
        begin
            // running status data collection
            data_seen = data_seen + 2'd1;
            if (data_seen == 2'd1)
            begin
                first_held = b;
            end
            if (data_seen >= data_need)
            begin
                d2 = (data_need == 2'd2) ? b[6:0] : 7'h00;
                data_seen = 2'd0;
                if (cur_status == ST_SONG_POS)
                begin
                    if (clock_fwd_on)
                    begin
                        found[n] = make_result(KIND_SONG_POS, cur_status, first_held, d2,
                                               1'b0);
                        n++;
                    end
                end
                else
                begin
                    found[n] = make_result(KIND_MESSAGE, cur_status, first_held, d2, 1'b0);
                    n++;
                end
            end
        end
        if (n > 0)
        begin
            found[n - 1].last_result = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            expected_results.push_back(found[i]);
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic ovr);
        midi_item_t it;
        it.value = b;
        it.ovr = ovr;
        pending_bytes.push_back(it);
        bytes_queued++;
    endtask

    // random byte with the odd real-time byte in front and a rare overrun
    task automatic queue_noisy(input logic [7:0] b);
        if ($urandom_range(99) < 4)
        begin
            queue_byte(8'($urandom_range(RT_LAST, ST_RT_FIRST)), 1'b0);
        end
        queue_byte(b, $urandom_range(99) < 4);
    endtask

    // one well-formed message, or a piece of noise
    task automatic queue_random_sequence();
        logic [7:0] st;
        int         pick;
        int         reps;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            st = 8'($urandom_range(STAT_CHANNEL_LAST, STAT_NOTE_OFF));
            queue_noisy(st);
            reps = $urandom_range(3);
            for (int i = 0; i <= reps; i++)
            begin
                repeat (data_bytes_for(st)) queue_noisy(8'($urandom_range(DATA_MAX)));
            end
        end
        else if (pick < 50)
        begin
            repeat ($urandom_range(2, 1)) queue_noisy(8'($urandom_range(DATA_MAX)));
        end
        else if (pick < 60)
        begin
            queue_noisy(ST_SX_START);
            repeat ($urandom_range(6)) queue_noisy(8'($urandom_range(DATA_MAX)));
            if ($urandom_range(9) < 7)
            begin
                queue_noisy(ST_SX_END);
            end
            else
            begin
                queue_noisy(8'($urandom_range(ST_SX_END, STAT_NOTE_OFF)));
            end
        end
        else if (pick < 67)
        begin
            queue_noisy(ST_QFRAME);
            queue_noisy(8'($urandom_range(DATA_MAX)));
        end
        else if (pick < 73)
        begin
            queue_noisy(ST_SONG_POS);
            repeat (2) queue_noisy(8'($urandom_range(DATA_MAX)));
        end
        else if (pick < 78)
        begin
            queue_noisy(8'($urandom_range(STAT_TUNE_REQ, ST_SONG_SEL)));
            queue_noisy(8'($urandom_range(DATA_MAX)));
        end
        else if (pick < 88)
        begin
            queue_noisy(8'($urandom_range(RT_LAST, ST_RT_FIRST)));
        end
        else
        begin
            queue_noisy(8'($urandom_range(255)));
        end
    endtask

    task automatic queue_random_bytes(input int count);
        int target;
        target = bytes_queued + count;
        while (bytes_queued < target)
        begin
            queue_random_sequence();
        end
    endtask

    // all bytes taken and all results seen, then let the pipeline settle
    task automatic wait_drained();
        while (bytes_taken != bytes_queued || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SYSEX_CAPTURE: capture_on = val;
            CFG_CLOCK_FORWARD: clock_fwd_on = val;
            default: ;
        endcase
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // input driver: presents the next item once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || byte_taken))
        begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_item = pending_bytes.pop_front();
                rx_byte <= next_item.value;
                overrun <= next_item.ovr;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: predicts on accepted items, checks result items, watchdog
    always @(posedge clk)
    begin : sample_ports
        res_t want;
        byte_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                frame_byte(rx_byte, overrun);
                bytes_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d status %h data %h",
                           kind, status_byte, first_data);
                    fails++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                        fails++;
                    end
                    if (status_byte !== want.status_byte)
                    begin
                        $error("status_byte: expected %h, got %h", want.status_byte,
                               status_byte);
                        fails++;
                    end
                    if (first_data !== want.first_data)
                    begin
                        $error("first_data: expected %h, got %h", want.first_data,
                               first_data);
                        fails++;
                    end
                    if (second_data !== want.second_data)
                    begin
                        $error("second_data: expected %h, got %h", want.second_data,
                               second_data);
                        fails++;
                    end
                    if (sysex_overflow !== want.sysex_overflow)
                    begin
                        $error("sysex_overflow: expected %b, got %b", want.sysex_overflow,
                               sysex_overflow);
                        fails++;
                    end
                    if (last_result !== want.last_result)
                    begin
                        $error("last_result: expected %b, got %b", want.last_result,
                               last_result);
                        fails++;
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // reset, configuration and stimulus phases
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part, everything forwarded
        set_idling(0, 0);
        write_reg(CFG_SYSEX_CAPTURE, 1'b1);
        write_reg(CFG_CLOCK_FORWARD, 1'b1);
        queue_byte(STAT_NOTE_OFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(DATA_MAX, 1'b0);
        // running status reuse
        queue_byte(DATA_MAX, 1'b0);
        queue_byte(8'h00, 1'b0);
        // one data byte message
        queue_byte(STAT_PROG_CHANGE | 8'h0F, 1'b0);
        queue_byte(8'h12, 1'b0);
        // real-time bytes, one of them undefined
        queue_byte(ST_CLOCK, 1'b0);
        queue_byte(RT_UNDEF, 1'b0);
        queue_byte(ST_START, 1'b0);
        queue_byte(ST_CONTINUE, 1'b0);
        queue_byte(ST_STOP, 1'b0);
        // quarter frame with a clock in between
        queue_byte(ST_QFRAME, 1'b0);
        queue_byte(ST_CLOCK, 1'b0);
        queue_byte(8'h55, 1'b0);
        // song position
        queue_byte(ST_SONG_POS, 1'b0);
        queue_byte(8'h10, 1'b0);
        queue_byte(DATA_MAX, 1'b0);
        // zero-length status drops data, stray end does nothing
        queue_byte(STAT_TUNE_REQ, 1'b0);
        queue_byte(8'h11, 1'b0);
        queue_byte(ST_SX_END, 1'b0);
        // sysex restarted by a new start, overrun inside sysex still streams
        queue_byte(ST_SX_START, 1'b0);
        queue_byte(8'h7E, 1'b0);
        queue_byte(ST_SX_START, 1'b0);
        queue_byte(8'h01, 1'b1);
        // quarter frame marker ends the sysex
        queue_byte(ST_QFRAME, 1'b0);
        queue_byte(8'h22, 1'b0);
        // overrun drops data until the next status
        queue_byte(STAT_PITCH_BEND | 8'h0F, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h02, 1'b1);
        queue_byte(ST_SONG_SEL, 1'b0);
        queue_byte(8'h05, 1'b0);
        queue_random_bytes(90);
        wait_drained();

        // clock only, sender idles a lot
        write_reg(CFG_SYSEX_CAPTURE, 1'b0);
        set_idling(66, 0);
        queue_random_bytes(90);
        wait_drained();

        // sysex only, receiver stalls, sender holds off midway
        write_reg(CFG_SYSEX_CAPTURE, 1'b1);
        write_reg(CFG_CLOCK_FORWARD, 1'b0);
        set_idling(0, 66);
        queue_random_bytes(45);
        wait_drained();
        queue_random_bytes(45);
        wait_drained();

        // sysex capture and clock forwarding off, both sides idle
        write_reg(CFG_SYSEX_CAPTURE, 1'b0);
        set_idling(36, 36);
        queue_random_bytes(90);
        wait_drained();

        // writes to unused indexes must not clear anything
        write_reg(CFG_SYSEX_CAPTURE, 1'b1);
        write_reg(CFG_CLOCK_FORWARD, 1'b1);
        write_reg(CFG_UNUSED_LO, 1'b0);
        write_reg(CFG_UNUSED_HI, 1'b0);
        queue_random_bytes(90);
        wait_drained();

        if (fails == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
